@@ sv/bfba_pkg.sv @@
// Package for the best-fit block allocator: word types, codes and defaults.
`timescale 1ns / 1ps

package bfba_pkg;

  // Default sizing
  localparam int DEF_NUM_BLOCKS  = 4;
  localparam int DEF_BLOCK_BYTES = 1024;
  localparam int DEF_NUM_SLOTS   = 16;

  // Fixed field widths of the request and result words
  localparam int SIZE_W     = 11;
  localparam int HANDLE_W   = 4;
  localparam int SLOT_OUT_W = 4;
  localparam int BLK_OUT_W  = 2;
  localparam int FREE_OUT_W = 11;

  // Live bits examined per cycle while hunting for a free slot
  localparam int GROUP_SIZE = 8;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } bfba_action_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FIT   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOT_LIVE = 2'd3
  } bfba_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_FREE_CHK,
    S_FREE_BLK,
    S_FREE_WB
  } bfba_state_t;

  typedef struct packed {
    bfba_action_t        action;
    logic [SIZE_W-1:0]   alloc_size;
    logic [HANDLE_W-1:0] handle;
  } bfba_req_t;

  typedef struct packed {
    bfba_status_t          status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [BLK_OUT_W-1:0]  block_index;
    logic [FREE_OUT_W-1:0] block_free;
  } bfba_rsp_t;

endpackage

@@ sv/bfba_free_ram.sv @@
// Free-space memory: one count per block, reads as the block size until written.
`timescale 1ns / 1ps

module bfba_free_ram
  import bfba_pkg::*;
#(
  parameter int DEPTH     = DEF_NUM_BLOCKS,
  parameter int WIDTH     = 11,
  parameter int RESET_VAL = DEF_BLOCK_BYTES,
  parameter int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;

  // Written flags: an unwritten entry holds the reset count
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (vld[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= WIDTH'(RESET_VAL);
    end
  end

endmodule

@@ sv/bfba_slot_ram.sv @@
// Slot table memory: size and block of each allocation, one write and one read port.
`timescale 1ns / 1ps

module bfba_slot_ram
  import bfba_pkg::*;
#(
  parameter int DEPTH  = DEF_NUM_SLOTS,
  parameter int WIDTH  = 13,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/best_fit_block_allocator.sv @@
// Best-fit block allocator: a scanning sequencer over the free-space and slot memories.
`timescale 1ns / 1ps

// One request word is taken when start is high and busy is low; its result word
// shows on result for exactly one cycle with done high, and must be captured then,
// since the block cannot be held off. An allocate walks the free-space memory one
// block per cycle (one read port, one compare) while checking eight live bits of
// the slot table per cycle, so it holds busy until every block and every group
// of live bits has been scanned and the result committed. A free does three
// dependent memory steps (slot read, free-space read, write back), and a free of a
// slot that is not live returns straight after the slot check. Busy holds off any
// new request until the result is out. A word never waits for the result receiver.

module best_fit_block_allocator
  import bfba_pkg::*;
#(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int NUM_SLOTS   = DEF_NUM_SLOTS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  bfba_req_t request,
  output logic      done,
  output bfba_rsp_t result
);

  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FREE_W     = $clog2(BLOCK_BYTES + 1);
  localparam int CMP_W      = (FREE_W > SIZE_W) ? FREE_W : SIZE_W;
  localparam int NUM_GROUPS = (NUM_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int PAD_W      = NUM_GROUPS * GROUP_SIZE;
  localparam int SCAN_LEN   = (NUM_BLOCKS > NUM_GROUPS) ? NUM_BLOCKS : NUM_GROUPS;
  localparam int CNT_W      = $clog2(SCAN_LEN + 1);
  localparam int ENC_W      = $clog2(GROUP_SIZE);
  localparam int ENT_W      = BLK_W + SIZE_W;

  bfba_state_t state, state_next;
  bfba_req_t   cmd;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic                 found, found_next;
  logic [BLK_W-1:0]     best_blk, best_blk_next;
  logic [FREE_W-1:0]    best_free, best_free_next;
  logic                 slot_found, slot_found_next;
  logic [SLOT_W-1:0]    free_slot, free_slot_next;
  logic                 rd_vld, rd_vld_next;
  logic [BLK_W-1:0]     rd_idx, rd_idx_next;
  logic [NUM_SLOTS-1:0] live, live_next;
  logic                 done_next;
  bfba_rsp_t            result_next;

  // Memory ports
  logic              fs_we;
  logic [BLK_W-1:0]  fs_waddr;
  logic [FREE_W-1:0] fs_wdata;
  logic [BLK_W-1:0]  fs_raddr;
  logic [FREE_W-1:0] fs_rdata;
  logic              sl_we;
  logic [SLOT_W-1:0] sl_waddr;
  logic [ENT_W-1:0]  sl_wdata;
  logic [SLOT_W-1:0] sl_raddr;
  logic [ENT_W-1:0]  sl_rdata;

  // Decode helpers
  logic                  accept;
  logic [SLOT_W-1:0]     hidx;
  logic                  handle_ok;
  logic [PAD_W-1:0]      live_pad;
  logic [GRP_W-1:0]      grp_idx;
  logic [GROUP_SIZE-1:0] grp_free;
  logic [ENC_W-1:0]      grp_enc;
  logic [BLK_W-1:0]      ent_blk;
  logic [SIZE_W-1:0]     ent_size;
  logic [CMP_W:0]        sum_free;
  logic [FREE_W-1:0]     new_free;

  bfba_free_ram #(
    .DEPTH     (NUM_BLOCKS),
    .WIDTH     (FREE_W),
    .RESET_VAL (BLOCK_BYTES),
    .ADDR_W    (BLK_W)
  ) u_free_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  bfba_slot_ram #(
    .DEPTH  (NUM_SLOTS),
    .WIDTH  (ENT_W),
    .ADDR_W (SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Handle decode for free requests
  assign hidx      = SLOT_W'(cmd.handle);
  assign handle_ok = (32'(cmd.handle) < NUM_SLOTS) && live[hidx];

  // Slot table entry fields
  assign ent_blk  = sl_rdata[SIZE_W +: BLK_W];
  assign ent_size = sl_rdata[SIZE_W-1:0];

  // Live bits padded with busy slots, examined one group per scan cycle
  always_comb begin
    live_pad                = '1;
    live_pad[NUM_SLOTS-1:0] = live;
  end

  assign grp_idx  = cnt[GRP_W-1:0];
  assign grp_free = ~live_pad[grp_idx*GROUP_SIZE +: GROUP_SIZE];

  // Lowest free bit within the group
  always_comb begin
    grp_enc = '0;
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (grp_free[i]) begin
        grp_enc = ENC_W'(i);
      end
    end
  end

  // Returned size added back to its block
  assign sum_free = (CMP_W + 1)'(fs_rdata) + (CMP_W + 1)'(ent_size);
  assign new_free = FREE_W'(sum_free);

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      live   <= '0;
      done   <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      live   <= live_next;
      done   <= done_next;
      rd_vld <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= request;
    end
    cnt        <= cnt_next;
    found      <= found_next;
    best_blk   <= best_blk_next;
    best_free  <= best_free_next;
    slot_found <= slot_found_next;
    free_slot  <= free_slot_next;
    rd_idx     <= rd_idx_next;
    result     <= result_next;
  end

  // Sequencer: next state, memory accesses and result word
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    found_next      = found;
    best_blk_next   = best_blk;
    best_free_next  = best_free;
    slot_found_next = slot_found;
    free_slot_next  = free_slot;
    rd_vld_next     = 1'b0;
    rd_idx_next     = cnt[BLK_W-1:0];
    live_next       = live;
    done_next       = 1'b0;
    result_next     = result;

    fs_we    = 1'b0;
    fs_waddr = best_blk;
    fs_wdata = FREE_W'(CMP_W'(best_free) - CMP_W'(cmd.alloc_size));
    fs_raddr = cnt[BLK_W-1:0];
    sl_we    = 1'b0;
    sl_waddr = free_slot;
    sl_wdata = {best_blk, cmd.alloc_size};
    sl_raddr = hidx;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cnt_next        = '0;
          found_next      = 1'b0;
          slot_found_next = 1'b0;
          if (request.action == ACT_FREE) begin
            state_next = S_FREE_CHK;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the read of block cnt
        rd_vld_next = (cnt < CNT_W'(NUM_BLOCKS));
        // Compare the block read last cycle
        if (rd_vld && (CMP_W'(fs_rdata) >= CMP_W'(cmd.alloc_size)) &&
            (!found || (best_free > fs_rdata))) begin
          found_next     = 1'b1;
          best_blk_next  = rd_idx;
          best_free_next = fs_rdata;
        end
        // Lowest free slot, one group per cycle
        if ((cnt < CNT_W'(NUM_GROUPS)) && !slot_found && (|grp_free)) begin
          slot_found_next = 1'b1;
          free_slot_next  = SLOT_W'({grp_idx, grp_enc});
        end
        if (cnt == CNT_W'(SCAN_LEN)) begin
          state_next = S_COMMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      S_COMMIT: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (!found) begin
          result_next.status      = STAT_NO_FIT;
          result_next.slot        = '0;
          result_next.block_index = '0;
          result_next.block_free  = '0;
        end else if (!slot_found) begin
          result_next.status      = STAT_FULL;
          result_next.slot        = '0;
          result_next.block_index = '0;
          result_next.block_free  = '0;
        end else begin
          fs_we                   = 1'b1;
          sl_we                   = 1'b1;
          live_next[free_slot]    = 1'b1;
          result_next.status      = STAT_OK;
          result_next.slot        = SLOT_OUT_W'(free_slot);
          result_next.block_index = BLK_OUT_W'(best_blk);
          result_next.block_free  = FREE_OUT_W'(fs_wdata);
        end
      end

      S_FREE_CHK: begin
        // Slot table read at the handle goes out this cycle
        if (!handle_ok) begin
          done_next               = 1'b1;
          state_next              = S_IDLE;
          result_next.status      = STAT_NOT_LIVE;
          result_next.slot        = cmd.handle;
          result_next.block_index = '0;
          result_next.block_free  = '0;
        end else begin
          state_next = S_FREE_BLK;
        end
      end

      S_FREE_BLK: begin
        fs_raddr   = ent_blk;
        state_next = S_FREE_WB;
      end

      S_FREE_WB: begin
        fs_we                   = 1'b1;
        fs_waddr                = ent_blk;
        fs_wdata                = new_free;
        live_next[hidx]         = 1'b0;
        done_next               = 1'b1;
        state_next              = S_IDLE;
        result_next.status      = STAT_OK;
        result_next.slot        = cmd.handle;
        result_next.block_index = BLK_OUT_W'(ent_blk);
        result_next.block_free  = FREE_OUT_W'(new_free);
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
